/* sv/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg: shared types and codes for the buddy block allocator
// Node states, result status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package bba_pkg;

    typedef enum logic [1:0] {
        NS_ABSENT = 2'd0,
        NS_FREE   = 2'd1,
        NS_SPLIT  = 2'd2,
        NS_ALLOC  = 2'd3
    } node_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_MEM   = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_BAD_OFF  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT,
        S_FIND_RD,
        S_FIND_CHK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_DONE
    } fsm_t;

endpackage

/* sv/bba_ram.sv */
// ----------------------------------------------------------------------------
// bba_ram: generic single-port synchronous RAM
// One write or read per cycle; read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1020
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* sv/buddy_block_allocator.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator: binary buddy allocator with node table in RAM
// Alloc: scan levels for a free count, scan the level's nodes, split down.
// Free: walk down from level 0 to the allocated node, then merge upward.
// ----------------------------------------------------------------------------
// Alloc work grows with the nodes scanned and the splits made; free work
//   with the levels visited and the merges; a request refused at once (bad
//   size, nothing free, offset out of range) goes straight to the result.
//   One item at a time; the node RAM port (one access per cycle, read data registered) sets the pace.
// After reset a clearing pass writes every node, TOP_BLOCKS*(2^LEVELS-1) of
//   them, while s_ready stays low. The result sits in an output register.
module buddy_block_allocator #(
    parameter int LEVELS         = 8,
    parameter int TOP_BLOCKS     = 4,
    parameter int MIN_BLOCK_LOG2 = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [19:0] s_req_size,
    input  logic [20:0] s_block_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [20:0] m_granted_offset
);
    import bba_pkg::*;

    localparam int NODES  = TOP_BLOCKS * ((1 << LEVELS) - 1);
    localparam int AW     = $clog2(NODES);
    localparam int LW     = $clog2(LEVELS);
    localparam int TOP_L2 = MIN_BLOCK_LOG2 + LEVELS - 1;
    localparam int IW     = $clog2(TOP_BLOCKS) + LEVELS;
    localparam int CW     = IW + 1;
    localparam int XW     = 42;

    fsm_t state_reg, state_next;

    logic [LW-1:0]      lvl_reg, lvl_next, tgt_reg, tgt_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [20:0]        off_reg, off_next;
    logic [1:0]         st_reg, st_next;
    logic [20:0]        go_reg, go_next;
    logic               mv_reg, mv_next;
    logic [1:0]         ms_reg, ms_next;
    logic [20:0]        mo_reg, mo_next;
    logic [CW-1:0]      fc_reg [LEVELS];
    logic [CW-1:0]      fc_next [LEVELS];
    logic [1:0]         phase_reg, phase_next;

    logic               we;
    logic [AW-1:0]      addr;
    logic [1:0]         wdata, rdata;

    bba_ram #(.WIDTH(2), .DEPTH(NODES)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    function automatic logic [AW-1:0] pos(input logic [LW-1:0] l, input logic [IW-1:0] i);
        logic [AW+IW:0] b;
        b = (AW+IW+1)'(TOP_BLOCKS) * (((AW+IW+1)'(1) << l) - 1'b1);
        return AW'(b + (AW+IW+1)'(i));
    endfunction

    function automatic logic [CW-1:0] nodes_at(input logic [LW-1:0] l);
        return CW'(CW'(TOP_BLOCKS) << l);
    endfunction

    // size rounding to target level
    logic [20:0]   sz_m1;
    logic [LW-1:0] tgt_calc;
    logic          size_bad;
    logic          no_free;
    always_comb begin
        int b;
        b = 0;
        sz_m1 = 21'(s_req_size) - 21'd1;
        for (int k = 0; k < 21; k++) begin
            if (sz_m1[k]) b = k + 1;
        end
        if (b < MIN_BLOCK_LOG2) b = MIN_BLOCK_LOG2;
        size_bad = (s_req_size == 20'd0) || (XW'(s_req_size) > (XW'(1) << TOP_L2));
        tgt_calc = (b > TOP_L2) ? '0 : LW'(TOP_L2 - b);
        no_free = 1'b1;
        for (int k = 0; k < LEVELS; k++) begin
            if (LW'(k) <= tgt_calc && fc_reg[k] != '0) no_free = 1'b0;
        end
    end

    logic [XW-1:0] node_start;
    logic          off_oob;
    always_comb begin
        off_oob    = XW'(s_block_offset) >= (XW'(TOP_BLOCKS) << TOP_L2);
        node_start = XW'(idx_reg) << (TOP_L2 - int'(lvl_reg));
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = mv_reg;
    assign m_status         = ms_reg;
    assign m_granted_offset = mo_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:     if (clr_reg == AW'(NODES - 1)) state_next = S_IDLE;
            S_IDLE: begin
                if (s_valid) begin
                    if (s_kind) state_next = off_oob ? S_DONE : S_FIND_RD;
                    else        state_next = (size_bad || no_free) ? S_DONE : S_SCAN_RD;
                end
            end
            S_SCAN_RD:   state_next = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (node_t'(rdata) == NS_FREE)
                    state_next = (lvl_reg == tgt_reg) ? S_DONE : S_SPLIT;
                else if (CW'(idx_reg) + 1'b1 >= nodes_at(lvl_reg)) state_next = S_DONE;
                else state_next = S_SCAN_RD;
            end
            S_SPLIT:     if (phase_reg == 2'd2 && lvl_reg + 1'b1 == tgt_reg)
                             state_next = S_DONE;
            S_FIND_RD:   state_next = S_FIND_CHK;
            S_FIND_CHK: begin
                if (node_t'(rdata) == NS_SPLIT && lvl_reg != LW'(LEVELS - 1))
                    state_next = S_FIND_RD;
                else if (node_t'(rdata) == NS_ALLOC && node_start == XW'(off_reg))
                    state_next = (lvl_reg == '0) ? S_DONE : S_MERGE_RD;
                else state_next = S_DONE;
            end
            S_MERGE_RD:  state_next = S_MERGE_CHK;
            S_MERGE_CHK: begin
                if (node_t'(rdata) != NS_FREE) state_next = S_DONE;
                else if (phase_reg == 2'd2 && lvl_reg == LW'(1)) state_next = S_DONE;
                else if (phase_reg == 2'd2) state_next = S_MERGE_RD;
            end
            S_DONE:      if (!mv_reg || m_ready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        lvl_next = lvl_reg; tgt_next = tgt_reg; idx_next = idx_reg;
        clr_next = clr_reg; off_next = off_reg; st_next = st_reg;
        go_next = go_reg; phase_next = phase_reg;
        ms_next = ms_reg; mo_next = mo_reg;
        mv_next = mv_reg && !m_ready;
        for (int k = 0; k < LEVELS; k++) fc_next[k] = fc_reg[k];
        we = 1'b0; addr = pos(lvl_reg, idx_reg); wdata = NS_ABSENT;
        unique case (state_reg)
            S_CLEAR: begin
                we = 1'b1; addr = clr_reg;
                wdata = (clr_reg < AW'(TOP_BLOCKS)) ? NS_FREE : NS_ABSENT;
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE: begin
                off_next = s_block_offset; idx_next = '0; phase_next = '0;
                st_next = ST_OK; go_next = '0; lvl_next = '0;
                if (s_valid && s_kind) begin
                    idx_next = IW'(XW'(s_block_offset) >> TOP_L2);
                    if (off_oob) st_next = ST_BAD_OFF;
                end else if (s_valid) begin
                    tgt_next = tgt_calc;
                    if (size_bad) st_next = ST_BAD_SIZE;
                    else begin
                        st_next = ST_NO_MEM;
                        for (int k = 0; k < LEVELS; k++)
                            if (LW'(k) <= tgt_calc && fc_reg[k] != '0) begin
                                lvl_next = LW'(k); st_next = ST_OK;
                            end
                    end
                end
            end
            S_SCAN_RD: ;
            S_SCAN_CHK: begin
                if (node_t'(rdata) == NS_FREE) begin
                    if (lvl_reg == tgt_reg) begin
                        we = 1'b1; wdata = NS_ALLOC;
                        fc_next[lvl_reg] = fc_reg[lvl_reg] - 1'b1;
                        go_next = 21'(node_start);
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                    if (CW'(idx_reg) + 1'b1 >= nodes_at(lvl_reg)) st_next = ST_NO_MEM;
                end
            end
            S_SPLIT: begin
                we = 1'b1;
                unique case (phase_reg)
                    2'd0: begin
                        wdata = NS_SPLIT;
                        fc_next[lvl_reg] = fc_reg[lvl_reg] - 1'b1;
                        phase_next = 2'd1;
                    end
                    2'd1: begin
                        addr = pos(lvl_reg + 1'b1, (idx_reg << 1) | IW'(1));
                        wdata = NS_FREE;
                        fc_next[lvl_reg + 1'b1] = fc_reg[lvl_reg + 1'b1] + 1'b1;
                        phase_next = 2'd2;
                    end
                    default: begin
                        addr = pos(lvl_reg + 1'b1, idx_reg << 1);
                        lvl_next = lvl_reg + 1'b1; idx_next = idx_reg << 1;
                        phase_next = 2'd0;
                        if (lvl_reg + 1'b1 == tgt_reg) begin
                            wdata = NS_ALLOC;
                            go_next = 21'(XW'(idx_reg << 1) << (TOP_L2 - int'(lvl_reg) - 1));
                        end else begin
                            wdata = NS_FREE;
                            fc_next[lvl_reg + 1'b1] = fc_reg[lvl_reg + 1'b1] + 1'b1;
                        end
                    end
                endcase
            end
            S_FIND_RD: ;
            S_FIND_CHK: begin
                if (node_t'(rdata) == NS_SPLIT && lvl_reg != LW'(LEVELS - 1)) begin
                    lvl_next = lvl_reg + 1'b1;
                    idx_next = IW'(XW'(off_reg) >> (TOP_L2 - int'(lvl_reg) - 1));
                end else if (node_t'(rdata) == NS_ALLOC && node_start == XW'(off_reg)) begin
                    we = 1'b1; wdata = NS_FREE;
                    fc_next[lvl_reg] = fc_reg[lvl_reg] + 1'b1;
                end else st_next = ST_BAD_OFF;
            end
            S_MERGE_RD: addr = pos(lvl_reg, idx_reg ^ IW'(1));
            S_MERGE_CHK: begin
                // read-before-write: in phases 1 and 2 rdata is the old FREE
                // value of the node written the cycle before
                if (node_t'(rdata) == NS_FREE) begin
                    we = 1'b1;
                    unique case (phase_reg)
                        2'd0: begin
                            addr = pos(lvl_reg, idx_reg);
                            fc_next[lvl_reg] = fc_reg[lvl_reg] - 1'b1;
                            phase_next = 2'd1;
                        end
                        2'd1: begin
                            addr = pos(lvl_reg, idx_reg ^ IW'(1));
                            fc_next[lvl_reg] = fc_reg[lvl_reg] - 1'b1;
                            phase_next = 2'd2;
                        end
                        default: begin
                            addr = pos(lvl_reg - 1'b1, idx_reg >> 1);
                            wdata = NS_FREE;
                            fc_next[lvl_reg - 1'b1] = fc_reg[lvl_reg - 1'b1] + 1'b1;
                            lvl_next = lvl_reg - 1'b1; idx_next = idx_reg >> 1;
                            phase_next = 2'd0;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    ms_next = st_reg;
                    mo_next = (st_reg == ST_OK) ? go_reg : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
            ms_reg    <= '0;
            mo_reg    <= '0;
            phase_reg <= '0;
            for (int k = 0; k < LEVELS; k++)
                fc_reg[k] <= (k == 0) ? CW'(TOP_BLOCKS) : '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
            ms_reg    <= ms_next;
            mo_reg    <= mo_next;
            phase_reg <= phase_next;
            for (int k = 0; k < LEVELS; k++) fc_reg[k] <= fc_next[k];
        end
        lvl_reg <= lvl_next; tgt_reg <= tgt_next; idx_reg <= idx_next;
        off_reg <= off_next; st_reg <= st_next; go_reg <= go_next;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("accept while busy");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_granted_offset == '0))
        else $error("offset on error");
`endif
endmodule
